FILE: design/hgmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgmm_pkg
// Shared types and constants of the height grid min-max normalizer.
// ----------------------------------------------------------------------------
package hgmm_pkg;

    // grid geometry; a cell lives at row * MAX_COLS + col
    localparam int COL_W    = 7;
    localparam int ROW_W    = 7;
    localparam int MAX_COLS = 2 ** COL_W;
    localparam int MAX_ROWS = 2 ** ROW_W;
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;

    localparam int SMP_W = 8;
    localparam int VAL_W = 16;
    localparam int CFG_W = 16;
    localparam int IDX_W = 2;

    // divider: magnitude of the scaled numerator stays below 2**24
    localparam int DIV_W     = 24;
    localparam int CNT_W     = $clog2(DIV_W);
    localparam int PROD_W    = 26;
    localparam int FLAT_DIVS = 255;
    localparam int FLAT_RND  = 127;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RLOW   = 2'd2,
        REG_RHIGH  = 2'd3
    } t_reg;

    typedef struct packed {
        logic accept;    // take the input transaction
        logic mul;       // form numerator and flat flag
        logic ld;        // load the divider
        logic step;      // one divider iteration
        logic fin;       // offset and saturate the quotient
        logic load_out;  // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic rd_go;     // offered transaction is an in-bounds read
        logic out_free;  // output register can take a result
    } t_stat;

endpackage
`default_nettype wire

FILE: design/height_grid_min_max_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// height_grid_min_max_normalizer
// 128 x 128 grid of 8-bit heights with min-max rescaling into signed Q8.8.
//
// Input stream: s_axis_tuser carries op (write, read, clear); s_axis_tdata
// carries col, row and sample. Output stream: one transaction per input
// transaction, m_axis_tdata = value (signed Q8.8), m_axis_tuser = status
// (1 = coordinates out of bounds). Registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while
// the block is idle; the block itself does not enforce it. A write,
// clear or rejected access is registered at acceptance and moved into
// the output register at hand-off. An in-bounds read (memory read at
// acceptance) then takes these steps: multiply, divider load, 24 divider
// iterations (one quotient bit per cycle), finish, hand-off. One transaction
// is processed at a time; the input is ready again the cycle after hand-off.
// The output register holds a result while the receiver stalls, and the
// next transaction is accepted and processed meanwhile; it then waits.
// Reset empties the output, restores the registers and restarts min/max
// tracking; the cell memory is not cleared and must be written before read.
// ----------------------------------------------------------------------------
module height_grid_min_max_normalizer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hgmm_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [hgmm_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [23:0]                 s_axis_tdata,  // col, row, sample, pad
    input  wire logic [1:0]                  s_axis_tuser,  // op
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [15:0]                      m_axis_tdata,  // value
    output logic [0:0]                       m_axis_tuser   // status
);

    hgmm_pkg::t_cmd  w_cmd;
    hgmm_pkg::t_stat w_stat;

    hgmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    hgmm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_col       (s_axis_tdata[6:0]),
        .i_row       (s_axis_tdata[13:7]),
        .i_sample    (s_axis_tdata[21:14]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_value     (m_axis_tdata),
        .o_status    (m_axis_tuser[0])
    );

`ifndef SYNTHESIS
    // one transaction at a time: input drops ready right after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still ready after acceptance");

    // a rejected access carries a zero value
    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("out-of-bounds result with nonzero value");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

FILE: design/hgmm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgmm_ctrl
// Sequencer: accept, multiply, iterative divide, finish (reads), hand off result.
// ----------------------------------------------------------------------------
module hgmm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  hgmm_pkg::t_stat      i_stat,
    output hgmm_pkg::t_cmd       o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_LD   = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [hgmm_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_stat.rd_go ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_LD;
            end
            S_LD: begin
                o_cmd.ld = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == hgmm_pkg::CNT_W'(hgmm_pkg::DIV_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register drains
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: design/hgmm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgmm_dp
// Datapath: config registers, cell memory, extremes, multiplier, divider,
// result and output registers.
// ----------------------------------------------------------------------------
module hgmm_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [hgmm_pkg::IDX_W-1:0]       i_cfg_idx,
    input  wire logic [hgmm_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic [1:0]                       i_op,
    input  wire logic [hgmm_pkg::COL_W-1:0]       i_col,
    input  wire logic [hgmm_pkg::ROW_W-1:0]       i_row,
    input  wire logic [hgmm_pkg::SMP_W-1:0]       i_sample,
    input  hgmm_pkg::t_cmd                        i_cmd,
    output hgmm_pkg::t_stat                       o_stat,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [hgmm_pkg::VAL_W-1:0]            o_value,
    output logic                                  o_status
);

    // configuration
    logic [7:0]                        r_width, r_height;
    logic signed [hgmm_pkg::VAL_W-1:0] r_rlo, r_rhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 8'd128;
            r_height <= 8'd128;
            r_rlo    <= 16'sd0;
            r_rhi    <= 16'sd256;
        end else if (i_cfg_we) begin
            case (hgmm_pkg::t_reg'(i_cfg_idx))
                hgmm_pkg::REG_WIDTH:  r_width  <= i_cfg_data[7:0];
                hgmm_pkg::REG_HEIGHT: r_height <= i_cfg_data[7:0];
                hgmm_pkg::REG_RLOW:   r_rlo    <= i_cfg_data;
                hgmm_pkg::REG_RHIGH:  r_rhi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // decode
    logic w_inb, w_wr, w_clr, w_oob;
    assign w_inb = ({1'b0, i_col} < r_width) && ({1'b0, i_row} < r_height);
    assign w_wr  = i_cmd.accept && (i_op == hgmm_pkg::OP_WRITE) && w_inb;
    assign w_clr = i_cmd.accept && (i_op == hgmm_pkg::OP_CLEAR);
    assign w_oob = ((i_op == hgmm_pkg::OP_WRITE) || (i_op == hgmm_pkg::OP_READ)) && !w_inb;
    assign o_stat.rd_go = (i_op == hgmm_pkg::OP_READ) && w_inb;

    // cell memory
    logic [hgmm_pkg::SMP_W-1:0]  r_mem [hgmm_pkg::DEPTH];
    logic [hgmm_pkg::SMP_W-1:0]  r_rd;
    logic [hgmm_pkg::ADDR_W-1:0] w_addr;
    assign w_addr = {i_row, i_col};

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_addr] <= i_sample;
        end
        // hold the cell of the accepted transaction for the whole read
        if (i_cmd.accept) begin
            r_rd <= r_mem[w_addr];
        end
    end

    // running extremes
    logic [hgmm_pkg::SMP_W-1:0] r_min, r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            r_min <= 8'd255;
            r_max <= 8'd0;
        end else if (w_wr) begin
            if (i_sample < r_min) r_min <= i_sample;
            if (i_sample > r_max) r_max <= i_sample;
        end
    end

    // numerator (sample - min) * (high - low)
    logic signed [8:0]                  w_ds;
    logic signed [16:0]                 w_dr;
    logic signed [hgmm_pkg::PROD_W-1:0] w_prod, r_num;
    logic                               r_flat;
    assign w_ds   = $signed({1'b0, r_rd}) - $signed({1'b0, r_min});
    assign w_dr   = 17'(r_rhi) - 17'(r_rlo);
    assign w_prod = hgmm_pkg::PROD_W'(w_ds) * hgmm_pkg::PROD_W'(w_dr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num  <= w_prod;
            r_flat <= (r_max <= r_min);
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [hgmm_pkg::DIV_W-1:0]  r_quo;
    logic [7:0]                  r_rem, r_dvs;
    logic                        r_neg;
    logic [8:0]                  w_sh;
    logic                        w_ge;
    logic [hgmm_pkg::PROD_W-1:0] w_abs;
    logic [hgmm_pkg::DIV_W-1:0]  w_flat_num;

    assign w_sh  = {r_rem, r_quo[hgmm_pkg::DIV_W-1]};
    assign w_ge  = (w_sh >= {1'b0, r_dvs});
    assign w_abs = r_num[hgmm_pkg::PROD_W-1] ? hgmm_pkg::PROD_W'(-r_num)
                                             : hgmm_pkg::PROD_W'(r_num);
    assign w_flat_num = hgmm_pkg::DIV_W'({r_rd, 8'd0})
                      + hgmm_pkg::DIV_W'(hgmm_pkg::FLAT_RND);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_rem <= '0;
            if (r_flat) begin
                r_quo <= w_flat_num;
                r_dvs <= 8'(hgmm_pkg::FLAT_DIVS);
                r_neg <= 1'b0;
            end else begin
                r_quo <= w_abs[hgmm_pkg::DIV_W-1:0];
                r_dvs <= r_max - r_min;
                r_neg <= r_num[hgmm_pkg::PROD_W-1];
            end
        end else if (i_cmd.step) begin
            r_rem <= w_ge ? 8'(w_sh - {1'b0, r_dvs}) : w_sh[7:0];
            r_quo <= {r_quo[hgmm_pkg::DIV_W-2:0], w_ge};
        end
    end

    // sign, offset, saturate
    logic signed [hgmm_pkg::PROD_W-1:0] w_q, w_sum;
    assign w_q   = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
    assign w_sum = w_q + (r_flat ? hgmm_pkg::PROD_W'(0) : hgmm_pkg::PROD_W'(r_rlo));

    logic [hgmm_pkg::VAL_W-1:0] r_res_value;
    logic                       r_res_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_value  <= '0;
            r_res_status <= w_oob;
        end else if (i_cmd.fin) begin
            if (w_sum > 26'sd32767) begin
                r_res_value <= 16'h7FFF;
            end else if (w_sum < -26'sd32768) begin
                r_res_value <= 16'h8000;
            end else begin
                r_res_value <= w_sum[hgmm_pkg::VAL_W-1:0];
            end
        end
    end

    // output register
    logic r_ovalid;
    logic [hgmm_pkg::VAL_W-1:0] r_ovalue;
    logic r_ostatus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_ovalue  <= r_res_value;
            r_ostatus <= r_res_status;
        end
    end

    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_value     = r_ovalue;
    assign o_status    = r_ostatus;

endmodule
`default_nettype wire
